### rtl/fir_same_mode_convolution_macros.svh
// Assertion macros for the FIR same-mode convolution block.
`ifndef FIR_SAME_MODE_CONVOLUTION_MACROS_SVH
`define FIR_SAME_MODE_CONVOLUTION_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, clocked on clk, off while rst_n is low
`define FSMC_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fsmc: same-cycle check failed");
// next-cycle implication
`define FSMC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fsmc: next-cycle check failed");
`else
`define FSMC_ASSERT(label, ante, cons)
`define FSMC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/fsmc_pkg.sv
// Shared types and constants for the FIR same-mode convolution block.
package fsmc_pkg;

    localparam int VALUE_W = 16;
    localparam int IDX_W   = 4;
    localparam int OUT_W   = 16;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;

    // item kinds held in the queue
    localparam logic KIND_TAP    = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // one queued beat
    typedef struct packed {
        logic               kind;
        logic [IDX_W-1:0]   idx;
        logic [VALUE_W-1:0] value;
        logic               last;
    } fsmc_item_t;

    // tag that travels alongside the arithmetic pipeline
    typedef struct packed {
        logic valid;
        logic eob;
    } fsmc_tag_t;

endpackage

### rtl/fsmc_front.sv
// Front end: takes input beats, tags them by kind and holds them in a short queue.
module fsmc_front #(
    parameter int TAPS = 15
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                func,
    input  logic [fsmc_pkg::IDX_W-1:0]          tap_index,
    input  logic signed [fsmc_pkg::VALUE_W-1:0] value,
    input  logic                                last,
    input  logic                                pop,
    output logic                                q_valid,
    output fsmc_pkg::fsmc_item_t                q_item
);
    import fsmc_pkg::*;

    fsmc_item_t         mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    fsmc_item_t         entry;
    logic               keep;
    logic               push;
    logic               do_pop;

    // classify: tap loads beyond the tap count are dropped here
    always_comb
    begin
        entry.kind  = func ? KIND_SAMPLE : KIND_TAP;
        entry.idx   = tap_index;
        entry.value = value;
        entry.last  = last;
        keep        = func || (int'(tap_index) < TAPS);
    end

    assign item_stall = (count_reg == QCNT_W'(QDEPTH));
    assign push       = item_valid && !item_stall && keep;
    assign do_pop     = pop && q_valid;
    assign q_valid    = (count_reg != '0);
    assign q_item     = mem_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

### rtl/fsmc_issue.sv
// Back-end sequencer: tap store, delay line, block position and flush steps.
module fsmc_issue #(
    parameter int TAPS        = 15,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  fsmc_pkg::fsmc_item_t          q_item,
    output logic                          pop,
    output logic                          flushing,
    input  logic                          adv,
    output fsmc_pkg::fsmc_tag_t           tag,
    output logic signed [SAMPLE_BITS-1:0] dl [TAPS],
    output logic signed [COEF_BITS-1:0]   coef [TAPS]
);
    import fsmc_pkg::*;

    localparam int HALF  = TAPS / 2;
    localparam int CNT_W = (HALF > 0) ? $clog2(HALF + 1) : 1;
    localparam logic [CNT_W-1:0] HALF_C = CNT_W'(HALF);

    localparam logic ST_RUN   = 1'b0;
    localparam logic ST_FLUSH = 1'b1;

    logic                          state_reg;
    logic                          state_next;
    logic [CNT_W-1:0]              seen_reg;
    logic [CNT_W-1:0]              seen_next;
    logic [CNT_W-1:0]              pos_reg;
    logic [CNT_W-1:0]              pos_next;
    logic [CNT_W-1:0]              step_reg;
    logic [CNT_W-1:0]              step_next;
    fsmc_tag_t                     tag_reg;
    fsmc_tag_t                     tag_next;
    logic signed [SAMPLE_BITS-1:0] dl_reg [TAPS];
    logic signed [COEF_BITS-1:0]   coef_reg [TAPS];
    logic                          shift;
    logic signed [SAMPLE_BITS-1:0] shift_val;
    logic                          tap_wr;
    logic signed [SAMPLE_BITS-1:0] sample_val;
    logic signed [COEF_BITS-1:0]   coef_val;

    // the 16-bit field widens with zeros or keeps its low bits
    assign sample_val = SAMPLE_BITS'(q_item.value);
    assign coef_val   = COEF_BITS'(q_item.value);

    // sequencing: one queue beat or one flush step per advancing cycle
    always_comb
    begin
        pop        = 1'b0;
        shift      = 1'b0;
        shift_val  = '0;
        tap_wr     = 1'b0;
        tag_next   = '0;
        state_next = state_reg;
        seen_next  = seen_reg;
        pos_next   = pos_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (q_valid && adv)
                begin
                    pop = 1'b1;
                    if (q_item.kind == KIND_SAMPLE)
                    begin
                        shift          = 1'b1;
                        shift_val      = sample_val;
                        tag_next.valid = (seen_reg == HALF_C);
                        if (seen_reg != HALF_C)
                        begin
                            seen_next = seen_reg + 1'b1;
                        end
                        if (q_item.last)
                        begin
                            seen_next = '0;
                            if (HALF == 0)
                            begin
                                tag_next.eob = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_FLUSH;
                                step_next  = CNT_W'(1);
                                pos_next   = seen_reg;
                            end
                        end
                    end
                    else
                    begin
                        tap_wr = 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (adv)
                begin
                    shift          = 1'b1;
                    tag_next.valid = ({1'b0, step_reg} + {1'b0, pos_reg}) >= {1'b0, HALF_C};
                    if (step_reg == HALF_C)
                    begin
                        tag_next.eob = 1'b1;
                        state_next   = ST_RUN;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // control and stored state; the delay line needs no clearing at block end,
    // since the zeros of the flush fill every slot a later output still reads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            seen_reg  <= '0;
            pos_reg   <= '0;
            step_reg  <= '0;
            tag_reg   <= '0;
            for (int i = 0; i < TAPS; i++)
            begin
                dl_reg[i]   <= '0;
                coef_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            seen_reg  <= seen_next;
            pos_reg   <= pos_next;
            step_reg  <= step_next;
            if (adv)
            begin
                tag_reg <= tag_next;
            end
            if (shift)
            begin
                dl_reg[0] <= shift_val;
                for (int i = 1; i < TAPS; i++)
                begin
                    dl_reg[i] <= dl_reg[i-1];
                end
            end
            for (int i = 0; i < TAPS; i++)
            begin
                if (tap_wr && (int'(q_item.idx) == i))
                begin
                    coef_reg[i] <= coef_val;
                end
            end
        end
    end

    assign tag      = tag_reg;
    assign dl       = dl_reg;
    assign coef     = coef_reg;
    assign flushing = (state_reg == ST_FLUSH);

endmodule

### rtl/fsmc_mac.sv
// Arithmetic pipeline: tap products, two-level adder tree, rounding, output register.
module fsmc_mac #(
    parameter int TAPS        = 15,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fsmc_pkg::fsmc_tag_t                 tag,
    input  logic signed [SAMPLE_BITS-1:0]       dl [TAPS],
    input  logic signed [COEF_BITS-1:0]         coef [TAPS],
    output logic                                adv,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [fsmc_pkg::OUT_W-1:0]   filtered,
    output logic                                end_of_block
);
    import fsmc_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W  = PROD_W + $clog2(TAPS) + 1;
    localparam int GRP    = 4;
    localparam int NGRP   = (TAPS + GRP - 1) / GRP;
    localparam logic signed [ACC_W:0] RND    = (ACC_W + 1)'(1) <<< (COEF_BITS - 2);
    localparam logic signed [ACC_W:0] SAT_HI =
        ((ACC_W + 1)'(1) <<< (SAMPLE_BITS - 1)) - (ACC_W + 1)'(1);
    localparam logic signed [ACC_W:0] SAT_LO = -SAT_HI - (ACC_W + 1)'(1);

    fsmc_tag_t                t1_reg;
    fsmc_tag_t                t2_reg;
    fsmc_tag_t                t3_reg;
    logic signed [PROD_W-1:0] prod_reg [TAPS];
    logic signed [ACC_W-1:0]  ext [NGRP*GRP];
    logic signed [ACC_W-1:0]  part_next [NGRP];
    logic signed [ACC_W-1:0]  part_reg [NGRP];
    logic signed [ACC_W-1:0]  sum_next;
    logic signed [ACC_W-1:0]  sum_reg;
    logic signed [ACC_W:0]    rsum;
    logic signed [ACC_W:0]    shifted;
    logic signed [ACC_W:0]    clamped;
    logic                     out_valid_reg;
    logic signed [OUT_W-1:0]  filtered_reg;
    logic                     eob_reg;

    // whole back end moves when the output register is free or being drained
    assign adv = !out_valid_reg || !result_stall;

    // widen products, pad the last group with zeros
    for (genvar i = 0; i < NGRP * GRP; i++)
    begin : g_ext
        if (i < TAPS)
        begin : g_live
            assign ext[i] = ACC_W'(prod_reg[i]);
        end
        else
        begin : g_pad
            assign ext[i] = '0;
        end
    end

    // first tree level: groups of four
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            part_next[g] = '0;
            for (int k = 0; k < GRP; k++)
            begin
                part_next[g] = part_next[g] + ext[g*GRP + k];
            end
        end
    end

    // second tree level
    always_comb
    begin
        sum_next = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            sum_next = sum_next + part_reg[g];
        end
    end

    // round half up, shift down to Q1.15, saturate
    always_comb
    begin
        rsum    = (ACC_W + 1)'(sum_reg) + RND;
        shifted = rsum >>> (COEF_BITS - 1);
        if (shifted > SAT_HI)
        begin
            clamped = SAT_HI;
        end
        else if (shifted < SAT_LO)
        begin
            clamped = SAT_LO;
        end
        else
        begin
            clamped = shifted;
        end
    end

    // control pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg        <= '0;
            t2_reg        <= '0;
            t3_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            t1_reg        <= tag;
            t2_reg        <= t1_reg;
            t3_reg        <= t2_reg;
            out_valid_reg <= t3_reg.valid;
        end
    end

    // data pipeline
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                prod_reg[i] <= PROD_W'(dl[i]) * PROD_W'(coef[i]);
            end
            part_reg     <= part_next;
            sum_reg      <= sum_next;
            filtered_reg <= OUT_W'(clamped);
            eob_reg      <= t3_reg.eob;
        end
    end

    assign result_valid = out_valid_reg;
    assign filtered     = filtered_reg;
    assign end_of_block = eob_reg;

endmodule

### rtl/fir_same_mode_convolution.sv
// Top level of the FIR same-mode convolution block.
//
//  channel  | handshake                | beat fields
//  ---------+--------------------------+--------------------------------------
//  item     | item_valid / item_stall  | func, tap_index, value, last
//  result   | result_valid/result_stall| filtered, end_of_block
//
// One beat is taken per cycle while the queue has room; a sample with last set holds
// the sequencer while the flush steps run through the single delay line.
// A sample's result is registered in turn in the queue, the sequencer, the product,
// the two tree levels and the output register.
// Reset clears the delay line, tap store and counters at once; no clearing pass.
// A stalled result freezes the whole back end; the four-entry queue keeps
// taking beats until it fills.
`include "fir_same_mode_convolution_macros.svh"

module fir_same_mode_convolution #(
    parameter int TAPS        = 15,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                func,
    input  logic [fsmc_pkg::IDX_W-1:0]          tap_index,
    input  logic signed [fsmc_pkg::VALUE_W-1:0] value,
    input  logic                                last,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [fsmc_pkg::OUT_W-1:0]   filtered,
    output logic                                end_of_block
);
    import fsmc_pkg::*;

    logic                          q_valid;
    fsmc_item_t                    q_item;
    logic                          pop;
    logic                          flushing;
    logic                          adv;
    fsmc_tag_t                     tag;
    logic signed [SAMPLE_BITS-1:0] dl [TAPS];
    logic signed [COEF_BITS-1:0]   coef [TAPS];

    fsmc_front #(
        .TAPS (TAPS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .func       (func),
        .tap_index  (tap_index),
        .value      (value),
        .last       (last),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_item     (q_item)
    );

    fsmc_issue #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_issue (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .pop      (pop),
        .flushing (flushing),
        .adv      (adv),
        .tag      (tag),
        .dl       (dl),
        .coef     (coef)
    );

    fsmc_mac #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_mac (
        .clk          (clk),
        .rst_n        (rst_n),
        .tag          (tag),
        .dl           (dl),
        .coef         (coef),
        .adv          (adv),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .filtered     (filtered),
        .end_of_block (end_of_block)
    );

    // checks
    `FSMC_ASSERT(a_no_issue_when_blocked, result_valid && result_stall, !pop)
    `FSMC_ASSERT(a_pop_has_data, pop, q_valid)
    `FSMC_ASSERT(a_flush_holds_queue, flushing, !pop)
    `FSMC_ASSERT_NEXT(a_full_queue_stays_full, item_stall && !pop, item_stall)

endmodule

### tb/fir_same_mode_convolution_tb.sv
// Self-checking testbench for the 15-tap same-mode FIR convolution block.
`timescale 1ns / 100ps

module fir_same_mode_convolution_tb;
    import fsmc_pkg::*;

    localparam int TAPS        = 15;
    localparam int HALF_TAPS   = TAPS / 2;
    localparam int ITEM_COUNT  = 430;
    localparam int DRAIN_AT    = 250;
    localparam int HOLD_AT     = 120;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 40;
    localparam int CYCLE_LIMIT = 200000;

    // one output beat as the filter should produce it
    typedef struct {
        logic [OUT_W-1:0] filtered;
        logic             eob;
    } out_beat_t;

    // one input beat waiting to be offered
    typedef struct {
        fsmc_item_t beat;
        bit         drain_first;
    } queued_beat_t;

    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      item_valid   = 1'b0;
    logic                      item_stall;
    logic                      func         = KIND_TAP;
    logic [IDX_W-1:0]          tap_index    = '0;
    logic signed [VALUE_W-1:0] value        = '0;
    logic                      last         = 1'b0;
    logic                      result_valid;
    logic                      result_stall = 1'b0;
    logic signed [OUT_W-1:0]   filtered;
    logic                      end_of_block;

    queued_beat_t beats_todo [$];
    out_beat_t    filtered_due [$];

    // filter state as the testbench tracks it
    logic signed [VALUE_W-1:0] model_delay [TAPS];
    logic signed [VALUE_W-1:0] model_taps  [TAPS];
    int                        model_seen;

    bit       item_taken = 1'b0;
    int       beats_in   = 0;
    int       fail_count = 0;
    int       cycle      = 0;
    int       gap_left   = 0;
    int       burst_left = 0;
    int       hold_left  = 0;
    bit       hold_done  = 1'b0;
    int       mode_left  = 0;
    int       rx_phase   = 0;
    rx_mode_t rx_mode    = RX_FREE;

    fir_same_mode_convolution u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .func         (func),
        .tap_index    (tap_index),
        .value        (value),
        .last         (last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .filtered     (filtered),
        .end_of_block (end_of_block)
    );

    always #5 clk = ~clk;

    // rounded, saturated Q1.15 sum of the current delay line against the taps
    function automatic logic [OUT_W-1:0] fir_sum();
        longint acc;
        longint r;
        acc = 0;
        for (int i = 0; i < TAPS; i++)
            acc += longint'(model_delay[i]) * longint'(model_taps[i]);
        acc += longint'(1) << 14;
        r = acc >>> 15;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[OUT_W-1:0];
    endfunction

    function automatic void delay_push(input logic signed [VALUE_W-1:0] s);
        for (int i = TAPS - 1; i > 0; i--)
            model_delay[i] = model_delay[i-1];
        model_delay[0] = s;
    endfunction

    // apply one accepted beat to the tracked state and queue its outputs
    task automatic fir_model_step(input fsmc_item_t beat);
        int        pos;
        out_beat_t burst [$];
        out_beat_t res;
        if (beat.kind == KIND_TAP)
        begin
            if (beat.idx < TAPS)
                model_taps[beat.idx] = beat.value;
        end
        else
        begin
            pos = model_seen;
            delay_push(beat.value);
            if (pos >= HALF_TAPS)
            begin
                res.filtered = fir_sum();
                res.eob      = 1'b0;
                burst.push_back(res);
            end
            else
            begin
                model_seen = pos + 1;
            end
            // flush: shift zeros through, emitting only indices that reach the centre
            if (beat.last)
            begin
                for (int f = 1; f <= HALF_TAPS; f++)
                begin
                    delay_push('0);
                    if (f + pos >= HALF_TAPS)
                    begin
                        res.filtered = fir_sum();
                        res.eob      = 1'b0;
                        burst.push_back(res);
                    end
                end
                if (burst.size() != 0)
                    burst[burst.size()-1].eob = 1'b1;
                for (int i = 0; i < TAPS; i++)
                    model_delay[i] = '0;
                model_seen = 0;
            end
            foreach (burst[k])
                filtered_due.push_back(burst[k]);
        end
    endtask

    task automatic queue_beat(input logic k, input int idx, input logic [VALUE_W-1:0] v,
                              input logic l, input bit drain);
        queued_beat_t q;
        q.beat.kind  = k;
        q.beat.idx   = idx[IDX_W-1:0];
        q.beat.value = v;
        q.beat.last  = l;
        q.drain_first = drain;
        beats_todo.push_back(q);
    endtask

    // full-range words half the time, with extremes and small values mixed in
    function automatic logic [VALUE_W-1:0] random_word();
        logic [VALUE_W-1:0] w;
        case ($urandom_range(0, 7))
            0: w = 16'h7fff;
            1: w = 16'h8000;
            2: w = VALUE_W'($urandom_range(0, 255));
            3: w = VALUE_W'(-$urandom_range(1, 256));
            default: w = VALUE_W'($urandom_range(0, 16'hffff));
        endcase
        return w;
    endfunction

    // stimulus, then drain and verdict
    initial
    begin
        int  total;
        int  len;
        bit  drain_set;
        bit  mark;
        for (int i = 0; i < TAPS; i++)
        begin
            model_delay[i] = '0;
            model_taps[i]  = '0;
        end
        model_seen = 0;
        drain_set  = 1'b0;

        // out-of-range tap with last set, then centre half, minus one, near plus one
        queue_beat(KIND_TAP, 15, 16'h7fff, 1'b1, 1'b0);
        queue_beat(KIND_TAP, 7, 16'h4000, 1'b0, 1'b0);
        queue_beat(KIND_TAP, 0, 16'h8000, 1'b0, 1'b0);
        queue_beat(KIND_TAP, 14, 16'h7fff, 1'b1, 1'b0);
        // one-sample blocks landing on a rounding tie, both signs
        queue_beat(KIND_SAMPLE, 0, 16'h0001, 1'b1, 1'b0);
        queue_beat(KIND_SAMPLE, 15, 16'hffff, 1'b1, 1'b0);
        // eight-sample block of extremes: saturation in the positive direction
        queue_beat(KIND_SAMPLE, 3, 16'h7fff, 1'b0, 1'b0);
        queue_beat(KIND_SAMPLE, 12, 16'h8000, 1'b0, 1'b0);
        queue_beat(KIND_SAMPLE, 5, 16'h7fff, 1'b0, 1'b0);
        queue_beat(KIND_SAMPLE, 10, 16'h8000, 1'b0, 1'b0);
        queue_beat(KIND_SAMPLE, 0, 16'h0001, 1'b0, 1'b0);
        queue_beat(KIND_SAMPLE, 15, 16'hffff, 1'b0, 1'b0);
        queue_beat(KIND_SAMPLE, 9, 16'h0000, 1'b0, 1'b0);
        queue_beat(KIND_SAMPLE, 6, 16'h7fff, 1'b1, 1'b0);
        // block of exactly half the taps
        for (int i = 0; i < HALF_TAPS; i++)
            queue_beat(KIND_SAMPLE, i, 16'h8000, i == HALF_TAPS - 1, 1'b0);
        total = beats_todo.size();

        // random blocks, with occasional tap reloads in between
        while (total < ITEM_COUNT)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    queue_beat(KIND_TAP, $urandom_range(0, 15),
                               $signed(random_word()) >>> $urandom_range(0, 4),
                               1'($urandom_range(0, 1)), 1'b0);
                    total++;
                end
            end
            len = ($urandom_range(0, 6) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
            begin
                // the first block start past the mark waits for the pipeline to empty
                mark = !drain_set && total >= DRAIN_AT && i == 0;
                queue_beat(KIND_SAMPLE, $urandom_range(0, 15), random_word(), i == len - 1,
                           mark);
                if (mark)
                    drain_set = 1'b1;
                total++;
            end
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (beats_todo.size() != 0 || item_valid)
            @(posedge clk);
        while (filtered_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // sender: bursts of beats with random gaps, holds a marked beat until drained
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else if (!item_valid || item_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                item_valid <= 1'b0;
            end
            else if (beats_todo.size() != 0 &&
                     !(beats_todo[0].drain_first && filtered_due.size() != 0))
            begin
                func       <= beats_todo[0].beat.kind;
                tap_index  <= beats_todo[0].beat.idx;
                value      <= beats_todo[0].beat.value;
                last       <= beats_todo[0].beat.last;
                item_valid <= 1'b1;
                void'(beats_todo.pop_front());
                if (burst_left > 0)
                    burst_left = burst_left - 1;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    case ($urandom_range(0, 5))
                        0, 1, 2: gap_left = 0;
                        3:       gap_left = $urandom_range(8, 20);
                        default: gap_left = $urandom_range(1, 6);
                    endcase
                end
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern that changes mode, plus one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (!hold_done && beats_in >= HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                result_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode   = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 80);
                end
                mode_left = mode_left - 1;
                rx_phase  = rx_phase + 1;
                case (rx_mode)
                    RX_FREE:     result_stall <= 1'b0;
                    RX_LIGHT:    result_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY:    result_stall <= ($urandom_range(0, 3) != 0);
                    default:     result_stall <= (rx_phase % 3 != 0);
                endcase
            end
        end
    end

    // monitor: predict on accepted input beats, check accepted output beats
    always @(posedge clk)
    begin
        fsmc_item_t in_beat;
        out_beat_t  want;
        if (rst_n)
        begin
            item_taken <= item_valid && !item_stall;
            if (item_valid && !item_stall)
            begin
                in_beat.kind  = func;
                in_beat.idx   = tap_index;
                in_beat.value = value;
                in_beat.last  = last;
                fir_model_step(in_beat);
                beats_in = beats_in + 1;
            end
            if (result_valid && !result_stall)
            begin
                if (filtered_due.size() == 0)
                begin
                    $error("unexpected output beat: filtered %0d end_of_block %0b",
                           filtered, end_of_block);
                    fail_count++;
                end
                else
                begin
                    want = filtered_due.pop_front();
                    if (filtered !== want.filtered)
                    begin
                        $error("filtered: expected %0d, got %0d",
                               $signed(want.filtered), filtered);
                        fail_count++;
                    end
                    if (end_of_block !== want.eob)
                    begin
                        $error("end_of_block: expected %0b, got %0b", want.eob, end_of_block);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle = cycle + 1;
        if (cycle >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
